/* design/usm_pkg.sv */
// Shared types, constants and helper functions of the unsharp-mask sharpener.
package usm_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_KERNEL = 9;
    localparam int MAX_HEIGHT     = 4096;
    localparam int Q_DEPTH        = 2;

    // Field widths sized for the full parameter range.
    localparam int COL_W  = 13;
    localparam int WID_W  = 14;
    localparam int HGT_W  = 13;
    localparam int ROW_W  = 12;
    localparam int SLOT_W = 4;
    localparam int RAD_W  = 3;
    localparam int CFG_W  = 13;
    localparam int PIX_W  = 8;
    localparam int GAIN_W = 12;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CFG_BOX_SIDE     = 2'd0,
        CFG_SHARPEN_GAIN = 2'd1,
        CFG_FRAME_WIDTH  = 2'd2,
        CFG_FRAME_HEIGHT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] pixel_in;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             line_end;
        logic             frame_end;
    } result_t;

    typedef struct packed {
        logic [3:0]        box_side;
        logic [GAIN_W-1:0] sharpen_gain;
        logic [11:0]       frame_width;
        logic [12:0]       frame_height;
    } cfg_t;

    // One unit of work for the back end: an optional line store write
    // followed by an optional output computation.
    typedef struct packed {
        logic              wr;
        logic [SLOT_W-1:0] wslot;
        logic [COL_W-1:0]  wcol;
        logic [PIX_W-1:0]  pix;
        logic              emit;
        logic [COL_W-1:0]  ox;
        logic [ROW_W-1:0]  oy;
        logic [SLOT_W-1:0] oslot;
        logic [WID_W-1:0]  w;
        logic [HGT_W-1:0]  h;
        logic [RAD_W-1:0]  r;
        logic              line_end;
        logic              frame_end;
    } job_t;

    // Position on a mirrored axis and the direction it moves as the
    // unmirrored index grows.
    typedef struct packed {
        logic [WID_W-1:0] p;
        logic             up;
    } bounce_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SEEK,
        B_SCAN,
        B_CENTER,
        B_LOAD,
        B_DIV,
        B_OUT
    } back_state_t;

    function automatic bounce_t bounce_up(input bounce_t b, input logic [WID_W-1:0] len);
        bounce_t n;
        n = b;
        if (len <= WID_W'(1)) begin
            n.p  = '0;
            n.up = 1'b1;
        end else if (b.up) begin
            if (b.p == len - WID_W'(1)) begin
                n.p  = len - WID_W'(2);
                n.up = 1'b0;
            end else begin
                n.p = b.p + WID_W'(1);
            end
        end else begin
            if (b.p == '0) begin
                n.p  = WID_W'(1);
                n.up = 1'b1;
            end else begin
                n.p = b.p - WID_W'(1);
            end
        end
        return n;
    endfunction

    function automatic bounce_t bounce_dn(input bounce_t b, input logic [WID_W-1:0] len);
        bounce_t n;
        n = b;
        if (len <= WID_W'(1)) begin
            n.p  = '0;
            n.up = 1'b1;
        end else if (b.up) begin
            if (b.p == '0) begin
                n.p  = WID_W'(1);
                n.up = 1'b0;
            end else begin
                n.p = b.p - WID_W'(1);
            end
        end else begin
            if (b.p == len - WID_W'(1)) begin
                n.p  = len - WID_W'(2);
                n.up = 1'b1;
            end else begin
                n.p = b.p + WID_W'(1);
            end
        end
        return n;
    endfunction

endpackage

/* design/box_unsharp_mask_sharpener.sv */
// Top level of the streaming box-blur unsharp-mask sharpener.
// A request is taken whenever the two-entry job queue has room, so requests
// that only fill the line store stream at one per cycle until the queue
// fills. Each result is produced by the back end, which reads the line store
// through its single read port one pixel per cycle; its restoring divider
// works on the window-sum width SUM_W (15 at the default MAX_KERNEL). A pixel
// request that makes no result only writes the line store in the back end.
// The line store holds no reset state and needs no clearing pass. Geometry is
// sampled on the first pixel of each frame, and the gain when each result is
// made.
module box_unsharp_mask_sharpener
    import usm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             item_valid,
    output logic             item_ready,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result
);

    cfg_t cfg_reg, cfg_next;
    logic q_push, q_full, q_pop, q_empty;
    job_t push_job, pop_job;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BOX_SIDE:     cfg_next.box_side     = cfg_data[3:0];
                CFG_SHARPEN_GAIN: cfg_next.sharpen_gain = cfg_data[GAIN_W-1:0];
                CFG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data[11:0];
                CFG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data[12:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_side     <= 4'd9;
            cfg_reg.sharpen_gain <= 12'd128;
            cfg_reg.frame_width  <= 12'd2048;
            cfg_reg.frame_height <= 13'd1024;
        end else
        begin
            cfg_reg <= cfg_next;
        end
    end

    usm_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_KERNEL(MAX_KERNEL)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .item_valid(item_valid),
        .item      (item),
        .item_ready(item_ready),
        .q_full    (q_full),
        .push      (q_push),
        .push_job  (push_job)
    );

    usm_queue #(
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (pop_job),
        .empty    (q_empty)
    );

    usm_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_KERNEL(MAX_KERNEL)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .gain        (cfg_reg.sharpen_gain),
        .job_valid   (!q_empty),
        .job         (pop_job),
        .job_pop     (q_pop),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

`ifndef NO_ASSERTIONS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from an empty queue");

    a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.frame_end) |-> result.line_end)
        else $error("frame end without line end");
`endif

endmodule

/* design/usm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module usm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/usm_queue.sv */
// Short job queue between the front end and the back end.
module usm_queue
    import usm_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    job_t            mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full     = (count_reg == CNTW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

endmodule

/* design/usm_front.sv */
// Front end: accepts requests, tracks frame geometry and positions, and queues jobs.
module usm_front
    import usm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  item_valid,
    input  item_t item,
    output logic  item_ready,
    input  logic  q_full,
    output logic  push,
    output job_t  push_job
);

    localparam int RMAX       = MAX_KERNEL / 2;
    localparam int STORE_ROWS = 2 * RMAX + 2;
    localparam int SW         = $clog2(STORE_ROWS);
    localparam int DLY_W      = $clog2(RMAX * MAX_WIDTH + RMAX + 1);
    localparam int RST_W      = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
    localparam int RST_R      = (RMAX < 4) ? RMAX : 4;
    localparam int RST_DLY    = RST_R * RST_W + RST_R;

    logic [COL_W-1:0] col_reg, col_next;
    logic [HGT_W-1:0] row_reg, row_next;
    logic [SW-1:0]    wslot_reg, wslot_next;
    logic [COL_W-1:0] oc_reg, oc_next;
    logic [ROW_W-1:0] or_reg, or_next;
    logic [SW-1:0]    oslot_reg, oslot_next;
    logic [DLY_W-1:0] owed_reg, owed_next;
    logic [DLY_W-1:0] pending_reg, pending_next;
    logic [DLY_W-1:0] delay_reg, delay_next;
    logic             full_reg, full_next;
    logic [WID_W-1:0] w_reg, w_next;
    logic [HGT_W-1:0] h_reg, h_next;
    logic [RAD_W-1:0] r_reg, r_next;

    logic                   accept, latch, pix_take, drain_take, emit, end_frame;
    logic [WID_W-1:0]       gw, w_cur;
    logic [HGT_W-1:0]       gh, h_cur;
    logic [RAD_W-1:0]       gr, r_cur, ks_half;
    logic [WID_W+RAD_W-1:0] dly_wide;
    logic [DLY_W-1:0]       delay_cur, owed_cur;
    logic                   line_end, frame_end;

    assign item_ready = !q_full;
    assign accept     = item_valid && !q_full;

    always_comb
    begin
        // Geometry as latched from the registers at the first pixel of a frame.
        ks_half = cfg.box_side[3:1];
        gr = (ks_half > RAD_W'(RMAX)) ? RAD_W'(RMAX) : ks_half;
        if (cfg.frame_width == '0)
        begin
            gw = WID_W'(1);
        end else if (WID_W'(cfg.frame_width) > WID_W'(MAX_WIDTH))
        begin
            gw = WID_W'(MAX_WIDTH);
        end else
        begin
            gw = WID_W'(cfg.frame_width);
        end
        if (cfg.frame_height == '0)
        begin
            gh = HGT_W'(1);
        end else if (cfg.frame_height > HGT_W'(MAX_HEIGHT))
        begin
            gh = HGT_W'(MAX_HEIGHT);
        end else
        begin
            gh = cfg.frame_height;
        end
        dly_wide = gw * gr + gr;

        pix_take   = accept && (op_t'(item.operation) == OP_PIXEL) && !full_reg;
        latch      = pix_take && (row_reg == '0) && (col_reg == '0);
        drain_take = accept && !pix_take && full_reg && (pending_reg != '0);

        w_cur     = latch ? gw : w_reg;
        h_cur     = latch ? gh : h_reg;
        r_cur     = latch ? gr : r_reg;
        delay_cur = latch ? DLY_W'(dly_wide) : delay_reg;
        owed_cur  = latch ? '0 : owed_reg;

        // A pixel produces a result once the delay of r lines and r pixels is filled.
        emit = pix_take ? (owed_cur == delay_cur) : drain_take;

        line_end  = ({1'b0, oc_reg} == w_cur - WID_W'(1));
        frame_end = line_end && ({1'b0, or_reg} == h_cur - HGT_W'(1));

        col_next     = col_reg;
        row_next     = row_reg;
        wslot_next   = wslot_reg;
        oc_next      = oc_reg;
        or_next      = or_reg;
        oslot_next   = oslot_reg;
        owed_next    = owed_reg;
        pending_next = pending_reg;
        delay_next   = delay_reg;
        full_next    = full_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        r_next       = r_reg;
        end_frame    = 1'b0;

        if (pix_take)
        begin
            w_next     = w_cur;
            h_next     = h_cur;
            r_next     = r_cur;
            delay_next = delay_cur;
            owed_next  = emit ? owed_cur : owed_cur + DLY_W'(1);
            if ({1'b0, col_reg} + WID_W'(1) == w_cur)
            begin
                col_next   = '0;
                row_next   = row_reg + HGT_W'(1);
                wslot_next = (wslot_reg == SW'(STORE_ROWS - 1)) ? '0 : wslot_reg + SW'(1);
            end else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end

        if (emit)
        begin
            if ({1'b0, oc_reg} + WID_W'(1) == w_cur)
            begin
                oc_next    = '0;
                or_next    = or_reg + ROW_W'(1);
                oslot_next = (oslot_reg == SW'(STORE_ROWS - 1)) ? '0 : oslot_reg + SW'(1);
            end else
            begin
                oc_next = oc_reg + COL_W'(1);
            end
        end

        // The whole frame is in: the outputs still owed leave on drain requests.
        if (pix_take && (row_next == h_cur))
        begin
            full_next    = 1'b1;
            pending_next = owed_next;
            end_frame    = (owed_next == '0);
        end

        if (drain_take)
        begin
            pending_next = pending_reg - DLY_W'(1);
            end_frame    = (pending_reg == DLY_W'(1));
        end

        if (end_frame)
        begin
            full_next  = 1'b0;
            col_next   = '0;
            row_next   = '0;
            wslot_next = '0;
            oc_next    = '0;
            or_next    = '0;
            oslot_next = '0;
        end

        push               = pix_take || emit;
        push_job.wr        = pix_take;
        push_job.wslot     = SLOT_W'(wslot_reg);
        push_job.wcol      = col_reg;
        push_job.pix       = item.pixel_in;
        push_job.emit      = emit;
        push_job.ox        = oc_reg;
        push_job.oy        = or_reg;
        push_job.oslot     = SLOT_W'(oslot_reg);
        push_job.w         = w_cur;
        push_job.h         = h_cur;
        push_job.r         = r_cur;
        push_job.line_end  = line_end;
        push_job.frame_end = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            wslot_reg   <= '0;
            oc_reg      <= '0;
            or_reg      <= '0;
            oslot_reg   <= '0;
            owed_reg    <= '0;
            pending_reg <= '0;
            delay_reg   <= DLY_W'(RST_DLY);
            full_reg    <= 1'b0;
            w_reg       <= WID_W'(RST_W);
            h_reg       <= HGT_W'(1024);
            r_reg       <= RAD_W'(RST_R);
        end else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            wslot_reg   <= wslot_next;
            oc_reg      <= oc_next;
            or_reg      <= or_next;
            oslot_reg   <= oslot_next;
            owed_reg    <= owed_next;
            pending_reg <= pending_next;
            delay_reg   <= delay_next;
            full_reg    <= full_next;
            w_reg       <= w_next;
            h_reg       <= h_next;
            r_reg       <= r_next;
        end
    end

endmodule

/* design/usm_back.sv */
// Back end: line store writes, window mean, sharpening and the output register.
module usm_back
    import usm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [GAIN_W-1:0] gain,
    input  logic              job_valid,
    input  job_t              job,
    output logic              job_pop,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    localparam int RMAX       = MAX_KERNEL / 2;
    localparam int STORE_ROWS = 2 * RMAX + 2;
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int SW         = $clog2(STORE_ROWS);
    localparam int AW         = SW + CW;
    localparam int AREA_MAX   = (2 * RMAX + 1) * (2 * RMAX + 1);
    localparam int AREA_W     = $clog2(AREA_MAX + 1);
    localparam int SUM_W      = $clog2(AREA_MAX * 255 + AREA_MAX / 2 + 1);
    localparam int DCNT_W     = $clog2(SUM_W);
    localparam int CNT_W      = $clog2(2 * RMAX + 1);

    function automatic logic [SW-1:0] slot_move(input logic [SW-1:0] slot,
                                                input logic [WID_W-1:0] p_old,
                                                input logic [WID_W-1:0] p_new);
        logic [SW-1:0] s;
        s = slot;
        if (p_new > p_old)
        begin
            s = (slot == SW'(STORE_ROWS - 1)) ? '0 : slot + SW'(1);
        end else if (p_new < p_old)
        begin
            s = (slot == '0) ? SW'(STORE_ROWS - 1) : slot - SW'(1);
        end
        return s;
    endfunction

    back_state_t       state_reg, state_next;
    job_t              job_reg, job_next;
    bounce_t           row_reg, row_next;
    bounce_t           col_reg, col_next;
    bounce_t           col0_reg, col0_next;
    logic [SW-1:0]     rslot_reg, rslot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  dy_reg, dy_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic              acc_en_reg, acc_en_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [AREA_W-1:0] rem_reg, rem_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [PIX_W-1:0]  ram_rdata;

    logic [WID_W-1:0]  wl, hl;
    logic [CNT_W-1:0]  two_r;
    logic [7:0]        side;
    bounce_t           rb, cb;
    logic [AREA_W:0]   trial;
    logic [PIX_W-1:0]  blur, high;
    logic [GAIN_W+PIX_W-1:0] prod;
    logic [GAIN_W+PIX_W-1:0] rnd;
    logic [GAIN_W:0]   val;
    logic              out_free;

    usm_ram #(
        .WIDTH(PIX_W),
        .DEPTH(STORE_ROWS * (2 ** CW))
    ) u_line_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(job.pix),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        wl    = job_reg.w;
        hl    = WID_W'(job_reg.h);
        two_r = CNT_W'({1'b0, job_reg.r, 1'b0});
        side  = {4'b0, job.r, 1'b1};
        rb    = bounce_dn(row_reg, hl);
        cb    = bounce_dn(col_reg, wl);
        trial = {rem_reg, dvd_reg[SUM_W-1]};
        blur  = dvd_reg[PIX_W-1:0];
        high  = (pix_reg > blur) ? pix_reg - blur : '0;
        prod  = gain * high;
        rnd   = prod + (GAIN_W+PIX_W)'(128);
        val   = {{(GAIN_W+1-PIX_W){1'b0}}, pix_reg} + {1'b0, rnd[GAIN_W+PIX_W-1:PIX_W]};

        state_next        = state_reg;
        job_next          = job_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        col0_next         = col0_reg;
        rslot_next        = rslot_reg;
        cnt_next          = cnt_reg;
        dy_next           = dy_reg;
        acc_next          = acc_reg;
        pix_next          = pix_reg;
        dvd_next          = dvd_reg;
        rem_next          = rem_reg;
        area_next         = area_reg;
        dcnt_next         = dcnt_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        acc_en_next       = (state_reg == B_SCAN);
        job_pop           = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = {job.wslot[SW-1:0], job.wcol[CW-1:0]};
        ram_raddr         = '0;

        if (acc_en_reg)
        begin
            acc_next = acc_reg + SUM_W'(ram_rdata);
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    ram_we  = job.wr;
                    if (job.emit)
                    begin
                        job_next   = job;
                        row_next   = '{p: WID_W'(job.oy), up: 1'b1};
                        col_next   = '{p: WID_W'(job.ox), up: 1'b1};
                        col0_next  = '{p: WID_W'(job.ox), up: 1'b1};
                        rslot_next = job.oslot[SW-1:0];
                        cnt_next   = '0;
                        dy_next    = '0;
                        acc_next   = '0;
                        area_next  = AREA_W'(side * side);
                        state_next = (job.r == '0) ? B_SCAN : B_SEEK;
                    end
                end
            end
            B_SEEK:
            begin
                // Walk r steps up and left to the window's corner.
                row_next   = rb;
                col_next   = cb;
                col0_next  = cb;
                rslot_next = slot_move(rslot_reg, row_reg.p, rb.p);
                if (cnt_reg + CNT_W'(1) == CNT_W'(job_reg.r))
                begin
                    cnt_next   = '0;
                    state_next = B_SCAN;
                end else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            B_SCAN:
            begin
                ram_raddr = {rslot_reg, col_reg.p[CW-1:0]};
                if (cnt_reg == two_r)
                begin
                    cnt_next   = '0;
                    col_next   = col0_reg;
                    row_next   = bounce_up(row_reg, hl);
                    rslot_next = slot_move(rslot_reg, row_reg.p, row_next.p);
                    if (dy_reg == two_r)
                    begin
                        state_next = B_CENTER;
                    end else
                    begin
                        dy_next = dy_reg + CNT_W'(1);
                    end
                end else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    col_next = bounce_up(col_reg, wl);
                end
            end
            B_CENTER:
            begin
                ram_raddr  = {job_reg.oslot[SW-1:0], job_reg.ox[CW-1:0]};
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                pix_next   = ram_rdata;
                dvd_next   = acc_reg + SUM_W'(area_reg >> 1);
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (trial >= {1'b0, area_reg})
                begin
                    rem_next = AREA_W'(trial - {1'b0, area_reg});
                    dvd_next = {dvd_reg[SUM_W-2:0], 1'b1};
                end else
                begin
                    rem_next = trial[AREA_W-1:0];
                    dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(SUM_W - 1))
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    result_valid_next     = 1'b1;
                    result_next.pixel_out = (val > (GAIN_W+1)'(255)) ? 8'hFF : val[PIX_W-1:0];
                    result_next.line_end  = job_reg.line_end;
                    result_next.frame_end = job_reg.frame_end;
                    state_next            = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            acc_en_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end else
        begin
            state_reg        <= state_next;
            acc_en_reg       <= acc_en_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        col0_reg   <= col0_next;
        rslot_reg  <= rslot_next;
        cnt_reg    <= cnt_next;
        dy_reg     <= dy_next;
        acc_reg    <= acc_next;
        pix_reg    <= pix_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        area_reg   <= area_next;
        dcnt_reg   <= dcnt_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
